// ===== rtl/ldts_pkg.sv =====
package ldts_pkg;

  localparam int MAX_SAMPLE_BITS = 16;
  localparam int TARGET_W        = 16;
  localparam int POW_W           = 24;                   // Q8.16 power of sqrt2
  localparam int SUM_W           = 26;                   // triple sum, 16 fraction bits
  localparam int RATIO_W         = 32;                   // Q16.16
  localparam int NUM_W           = 49;                   // maxval << 32 plus rounding term
  localparam int PROD_W          = SUM_W + RATIO_W;
  localparam int LEVEL_W         = PROD_W + 1 - 24;      // scaled level, Q.8
  localparam int ERR_W           = 24;
  localparam int ACC_W           = 48;
  localparam int OUT_TDATA_W     = 104;
  localparam int CFG_INDEX_W     = 3;
  localparam int CFG_DATA_W      = 5;
  localparam int DIV_CNT_W       = 6;

  localparam logic [SUM_W-1:0]   THREE_Q16 = SUM_W'(196608);
  localparam logic [ERR_W-1:0]   ERR_SAT   = 24'hFFFF00;
  localparam logic [PROD_W:0]    ROUND_Q24 = (PROD_W+1)'(1) << 23;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(NUM_W);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SAMPLE_BITS    = 3'd0,
    CFG_SIGNED_SAMPLES = 3'd1,
    CFG_TOP_LEVEL_A    = 3'd2,
    CFG_TOP_LEVEL_B    = 3'd3,
    CFG_TOP_LEVEL_C    = 3'd4
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SEARCH,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic               done;
    logic [RATIO_W-1:0] ratio;
  } div_status_t;

  function automatic logic [POW_W-1:0] pow_q16(input logic [3:0] k);
    logic [POW_W-1:0] p;
    case (k)
      4'd0:    p = 24'd65536;
      4'd1:    p = 24'd92682;
      4'd2:    p = 24'd131072;
      4'd3:    p = 24'd185364;
      4'd4:    p = 24'd262144;
      4'd5:    p = 24'd370728;
      4'd6:    p = 24'd524288;
      4'd7:    p = 24'd741455;
      4'd8:    p = 24'd1048576;
      4'd9:    p = 24'd1482910;
      4'd10:   p = 24'd2097152;
      4'd11:   p = 24'd2965821;
      4'd12:   p = 24'd4194304;
      4'd13:   p = 24'd5931642;
      4'd14:   p = 24'd8388608;
      default: p = 24'd11863283;
    endcase
    return p;
  endfunction

  function automatic logic [SUM_W-1:0] triple_sum(input logic [3:0] a,
                                                  input logic [3:0] b,
                                                  input logic [3:0] c);
    logic [SUM_W-1:0] s;
    s = SUM_W'(pow_q16(a)) + SUM_W'(pow_q16(b)) + SUM_W'(pow_q16(c)) - THREE_Q16;
    return s;
  endfunction

endpackage

// ===== rtl/ldts_ratio_div.sv =====
module ldts_ratio_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ldts_pkg::NUM_W-1:0]     num,
  input  logic [ldts_pkg::SUM_W-1:0]     den,
  output ldts_pkg::div_status_t          status
);

  logic [ldts_pkg::NUM_W-1:0]     num_sh;
  logic [ldts_pkg::NUM_W-1:0]     quo;
  logic [ldts_pkg::SUM_W-1:0]     rem;
  logic [ldts_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy;
  logic                           done;

  logic [ldts_pkg::SUM_W:0]       shifted;
  logic                           ge;
  logic [ldts_pkg::SUM_W:0]       diff;
  logic [ldts_pkg::SUM_W-1:0]     rem_next;

  // one restoring step per cycle, msb first
  always_comb begin
    shifted  = {rem, num_sh[ldts_pkg::NUM_W-1]};
    ge       = shifted >= {1'b0, den};
    diff     = shifted - {1'b0, den};
    rem_next = ge ? diff[ldts_pkg::SUM_W-1:0] : shifted[ldts_pkg::SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= ldts_pkg::DIV_STEPS;
      end else if (busy) begin
        cnt <= cnt - ldts_pkg::DIV_CNT_W'(1);
        if (cnt == ldts_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num;
      rem    <= '0;
      quo    <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[ldts_pkg::NUM_W-2:0], 1'b0};
      rem    <= rem_next;
      quo    <= {quo[ldts_pkg::NUM_W-2:0], ge};
    end
  end

  // saturate anything past 32 bits; a zero divisor yields all ones here too
  assign status.done  = done;
  assign status.ratio = (|quo[ldts_pkg::NUM_W-1:ldts_pkg::RATIO_W])
                        ? '1 : quo[ldts_pkg::RATIO_W-1:0];

endmodule

// ===== rtl/log_dac_level_triple_search_unit.sv =====
// Three-channel logarithmic DAC level search.
//
// Input stream (s_*): one beat carries a 16-bit target PCM level.
// Output stream (m_*): one beat per input with the table slot, the best
// volume triple (high >= mid >= low), its Q16.8 error and the saturating
// Q40.8 running error total.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 sample_bits, 1 signed_samples, 2..4 top levels a, b, c); other
// indexes are ignored. Write only while no item is in flight.
//
// An item passes from input beat to output beat through the bit-serial
// divider forming the scale ratio (49 steps and a hand-off), the issue
// of all 816 triples, one a cycle, into the four-stage sum/multiply/
// error/compare pipeline, a drain of it and the posting of the result.
// One item at a time: s_tready is high only while the search sequencer
// is idle and out of reset, so no beat is taken while an item is in
// flight. A result waiting on m_tready does not block the next input
// beat; the next item holds in its finish state until the output
// register frees.
// Reset restores the register defaults and clears the error total.
module log_dac_level_triple_search_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [ldts_pkg::TARGET_W-1:0]        s_tdata,   // target_level[15:0]
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // table_slot[15:0], volume_high[19:16], volume_mid[23:20], volume_low[27:24],
  // match_error[51:28], error_total[99:52], zero pad [103:100]
  output logic [ldts_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                 cfg_we,
  input  logic [ldts_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ldts_pkg::CFG_DATA_W-1:0]      cfg_data
);

  ldts_pkg::state_t state, state_next;

  logic [4:0] sample_bits;
  logic       signed_samples;
  logic [3:0] top_a, top_b, top_c;

  logic [ldts_pkg::ACC_W-1:0] acc;

  logic                          accept;
  logic                          issue;
  logic                          load_out;
  logic                          issue_last;
  logic                          pipe_busy;

  logic [4:0]                    bits_eff;
  logic [ldts_pkg::TARGET_W-1:0] maxval;
  logic [ldts_pkg::TARGET_W-1:0] flip_mask;
  logic [ldts_pkg::SUM_W-1:0]    s_top;
  logic [ldts_pkg::NUM_W-1:0]    div_num;
  ldts_pkg::div_status_t         div_status;

  logic [ldts_pkg::TARGET_W-1:0] target;
  logic [ldts_pkg::RATIO_W-1:0]  ratio;
  logic [3:0]                    ia, ib, ic;

  logic                          v1, v2, v3;
  logic [ldts_pkg::SUM_W-1:0]    s1;
  logic [ldts_pkg::PROD_W-1:0]   prod2;
  logic [ldts_pkg::LEVEL_W-1:0]  e3;
  logic [11:0]                   tag1, tag2, tag3;

  logic [ldts_pkg::PROD_W:0]     rounded;
  logic [ldts_pkg::LEVEL_W-1:0]  level_q8;
  logic [ldts_pkg::LEVEL_W-1:0]  target_q8;

  logic                          best_valid;
  logic [ldts_pkg::LEVEL_W-1:0]  best_err;
  logic [11:0]                   best_tag;

  logic [ldts_pkg::ERR_W-1:0]    merr;
  logic [ldts_pkg::ACC_W:0]      acc_sum;
  logic [ldts_pkg::ACC_W-1:0]    acc_next;

  logic [ldts_pkg::TARGET_W-1:0] out_slot;
  logic [3:0]                    out_vh, out_vm, out_vl;
  logic [ldts_pkg::ERR_W-1:0]    out_err;
  logic [ldts_pkg::ACC_W-1:0]    out_total;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_bits    <= 5'd8;
      signed_samples <= 1'b1;
      top_a          <= 4'd15;
      top_b          <= 4'd15;
      top_c          <= 4'd15;
    end else if (cfg_we) begin
      case (cfg_index)
        ldts_pkg::CFG_SAMPLE_BITS:    sample_bits    <= cfg_data;
        ldts_pkg::CFG_SIGNED_SAMPLES: signed_samples <= cfg_data[0];
        ldts_pkg::CFG_TOP_LEVEL_A:    top_a          <= cfg_data[3:0];
        ldts_pkg::CFG_TOP_LEVEL_B:    top_b          <= cfg_data[3:0];
        ldts_pkg::CFG_TOP_LEVEL_C:    top_c          <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (sample_bits == 5'd0) begin
      bits_eff = 5'd1;
    end else if (sample_bits > 5'(ldts_pkg::MAX_SAMPLE_BITS)) begin
      bits_eff = 5'(ldts_pkg::MAX_SAMPLE_BITS);
    end else begin
      bits_eff = sample_bits;
    end
    maxval    = ldts_pkg::TARGET_W'((17'd1 << bits_eff) - 17'd1);
    flip_mask = ldts_pkg::TARGET_W'(17'd1 << (bits_eff - 5'd1));
    s_top     = ldts_pkg::triple_sum(top_a, top_b, top_c);
    div_num   = {1'b0, maxval, 32'd0} + ldts_pkg::NUM_W'(s_top[ldts_pkg::SUM_W-1:1]);
  end

  ldts_ratio_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .num    (div_num),
    .den    (s_top),
    .status (div_status)
  );

  // sequencer
  assign issue_last = (ia == 4'd0) && (ib == 4'd0) && (ic == 4'd0);
  assign pipe_busy  = v1 || v2 || v3;

  always_comb begin
    state_next = state;
    case (state)
      ldts_pkg::ST_IDLE:   if (s_tvalid) state_next = ldts_pkg::ST_DIVIDE;
      ldts_pkg::ST_DIVIDE: if (div_status.done) state_next = ldts_pkg::ST_SEARCH;
      ldts_pkg::ST_SEARCH: if (issue_last) state_next = ldts_pkg::ST_DRAIN;
      ldts_pkg::ST_DRAIN:  if (!pipe_busy) state_next = ldts_pkg::ST_FINISH;
      ldts_pkg::ST_FINISH: if (!m_tvalid || m_tready) state_next = ldts_pkg::ST_IDLE;
      default:             state_next = ldts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ldts_pkg::ST_IDLE) && !rst;
    issue    = (state == ldts_pkg::ST_SEARCH);
    load_out = (state == ldts_pkg::ST_FINISH) && (!m_tvalid || m_tready);
  end

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ldts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      target <= s_tdata;
    end
    if (div_status.done) begin
      ratio <= div_status.ratio;
    end
  end

  // triple walk: a down from 15, b up to a, c up to b
  always_ff @(posedge clk) begin
    if (accept) begin
      ia <= 4'd15;
      ib <= 4'd0;
      ic <= 4'd0;
    end else if (issue) begin
      if (ic < ib) begin
        ic <= ic + 4'd1;
      end else if (ib < ia) begin
        ib <= ib + 4'd1;
        ic <= 4'd0;
      end else begin
        ia <= ia - 4'd1;
        ib <= 4'd0;
        ic <= 4'd0;
      end
    end
  end

  // evaluation pipeline: sum, multiply, error, compare
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign rounded   = {1'b0, prod2} + ldts_pkg::ROUND_Q24;
  assign level_q8  = rounded[ldts_pkg::PROD_W:24];
  assign target_q8 = ldts_pkg::LEVEL_W'({target, 8'd0});

  always_ff @(posedge clk) begin
    s1    <= ldts_pkg::triple_sum(ia, ib, ic);
    tag1  <= {ia, ib, ic};
    prod2 <= ldts_pkg::PROD_W'(s1) * ldts_pkg::PROD_W'(ratio);
    tag2  <= tag1;
    e3    <= (level_q8 >= target_q8) ? level_q8 - target_q8 : target_q8 - level_q8;
    tag3  <= tag2;
  end

  // strict less keeps the earliest triple on ties
  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
    end else if (accept) begin
      best_valid <= 1'b0;
    end else if (v3 && (!best_valid || e3 < best_err)) begin
      best_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (v3 && (!best_valid || e3 < best_err)) begin
      best_err <= e3;
      best_tag <= tag3;
    end
  end

  // result and running total
  always_comb begin
    merr     = (best_err > ldts_pkg::LEVEL_W'(ldts_pkg::ERR_SAT))
               ? ldts_pkg::ERR_SAT : best_err[ldts_pkg::ERR_W-1:0];
    acc_sum  = {1'b0, acc} + (ldts_pkg::ACC_W+1)'(merr);
    acc_next = acc_sum[ldts_pkg::ACC_W] ? '1 : acc_sum[ldts_pkg::ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load_out) begin
        acc      <= acc_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_slot  <= signed_samples ? (target ^ flip_mask) : target;
      out_vh    <= best_tag[11:8];
      out_vm    <= best_tag[7:4];
      out_vl    <= best_tag[3:0];
      out_err   <= merr;
      out_total <= acc_next;
    end
  end

  assign m_tdata = {4'd0, out_total, out_err, out_vl, out_vm, out_vh, out_slot};

  a_pipe_empty_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ldts_pkg::ST_IDLE) |-> !pipe_busy)
    else $error("search pipeline busy while idle");

  a_err_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_err <= ldts_pkg::ERR_SAT))
    else $error("match error above saturation");

  a_acc_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (acc >= $past(acc)))
    else $error("error total decreased");

  a_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_vh >= out_vm) && (out_vm >= out_vl))
    else $error("volume triple out of order");

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ldts_pkg::ST_FINISH))
    else $error("result posted outside finish");

endmodule
